FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define GCL_ASSERT_CLK(lbl, c, r, prop) \
  lbl: assert property (@(posedge c) disable iff (!r) prop) \
    else $error("assertion failed");

// Same, on the usual clk / rst_n pair.
`define GCL_ASSERT(lbl, prop) `GCL_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

FILE: design/gcl_pkg.sv
`timescale 1ns / 1ps

package gcl_pkg;

  localparam int ACTION_W   = 3;
  localparam int ID_W       = 16;
  localparam int DIST_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int CMP_W      = 17;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAP_W      = 32;
  localparam int MAP_SH     = 5;
  localparam int ID_SPACE   = 65536;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_START  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_VISIT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_OFFER  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_EXPAND = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VISITED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EXPANDED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd6;
  localparam logic [STATUS_W-1:0] ST_RESULT    = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIST_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_NODE   = 2'd2;

  localparam logic [CMP_W-1:0] CMP_MAX = 17'd65536;

  typedef struct packed {
    logic [DIST_W-1:0] key;
    logic [ID_W-1:0]   id;
    logic              expd;
  } cand_t;

endpackage

FILE: design/gcl_if.sv
`timescale 1ns / 1ps

interface gcl_in_if;
  import gcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     node_id;
  logic [DIST_W-1:0]   dist_key;

  modport source (output valid, output action, output node_id, output dist_key, input ready);
  modport sink   (input valid, input action, input node_id, input dist_key, output ready);
endinterface

interface gcl_out_if;
  import gcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     node_id_out;
  logic [DIST_W-1:0]   dist_out;
  logic [CMP_W-1:0]    compare_count;
  logic                last;

  modport source (output valid, output status, output node_id_out, output dist_out,
                  output compare_count, output last, input ready);
  modport sink   (input valid, input status, input node_id_out, input dist_out,
                  input compare_count, input last, output ready);
endinterface

FILE: design/graph_search_candidate_list.sv
// A visit check reads the bitmap row of the id (an id beyond NODES skips the read); expand
// scans from the head for the best unexpanded entry; offer scans for the insert position,
// then moves each entry behind it up one slot; read-out sends one result beat per entry.
// The block takes one request at a time; one list RAM port pair and one key comparator
// are reused by a sequencer. Start and reset both sweep the visited bitmap, one 32-bit row
// a cycle; in ready stays low meanwhile.
`timescale 1ns / 1ps

module graph_search_candidate_list #(
  parameter int NODES    = 65536,
  parameter int MAX_LIST = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [gcl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcl_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  gcl_in_if.sink                          in_ch,
  gcl_out_if.source                       out_ch
);
  import gcl_pkg::*;

  // Only ids below 65536 can arrive, so the bitmap never needs to cover more ids than that.
  localparam int MAP_NODES = (NODES < ID_SPACE) ? NODES : ID_SPACE;
  localparam int ROWS      = (MAP_NODES + MAP_W - 1) / MAP_W;
  localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW        = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam logic [RAW-1:0]   ROW_LAST = RAW'(ROWS - 1);
  localparam logic [31:0]      NODES_W  = 32'(NODES);
  localparam logic [CNT_W-1:0] LIST_MAX = CNT_W'(MAX_LIST);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START_FIN, S_VIS_RD, S_VIS_CHK, S_SCAN_RD, S_SCAN_CMP, S_DECIDE,
    S_SHIFT_RD, S_SHIFT_WR, S_INS, S_EXP_RD, S_EXP_CHK, S_RO_RD, S_RO_OUT, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [CNT_W-1:0] list_limit_r;
  logic [CNT_W-1:0] result_count_r;
  logic [ID_W-1:0]  start_node_r;

  // search state
  logic [CNT_W-1:0] cand_count_r;
  logic [CMP_W-1:0] cmp_r;

  // working registers of the current beat
  logic [ID_W-1:0]   nid_r;
  logic [DIST_W-1:0] dk_r;
  logic [CNT_W-1:0]  p_r;      // insert position
  logic [CNT_W-1:0]  i_r;      // scan / shift / read-out index
  logic [CNT_W-1:0]  n_r;      // read-out length
  logic [RAW-1:0]    clr_r;
  logic              start_pend_r;

  // result staged for single-beat answers
  logic [STATUS_W-1:0] res_st_r;
  logic [ID_W-1:0]     res_id_r;
  logic [DIST_W-1:0]   res_dist_r;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_st_r;
  logic [ID_W-1:0]     out_id_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [CMP_W-1:0]    out_cmp_r;
  logic                out_last_r;

  // candidate list RAM
  cand_t            cand_mem [MAX_LIST];
  cand_t            cand_rd_r;
  logic [CNT_W-1:0] cand_ra;
  logic [CNT_W-1:0] cand_wa;
  logic             cand_we;
  cand_t            cand_wd;

  // visited bitmap RAM, 32 ids per row
  logic [MAP_W-1:0] map_mem [ROWS];
  logic [MAP_W-1:0] map_rd_r;
  logic [RAW-1:0]   map_addr;
  logic             map_we;
  logic [MAP_W-1:0] map_wd;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic [CNT_W-1:0] eff_lim;
  logic [CNT_W-1:0] ro_len;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] new_cnt;
  logic             key_less;
  logic             nid_ok;
  logic             start_ok;
  logic [MAP_W-1:0] nid_mask;
  logic [MAP_W-1:0] start_mask;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  // a new beat enters the output register this cycle
  assign out_load    = out_free && (state_r == S_EMIT || state_r == S_RO_OUT);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.node_id_out   = out_id_r;
  assign out_ch.dist_out      = out_dist_r;
  assign out_ch.compare_count = out_cmp_r;
  assign out_ch.last          = out_last_r;

  // effective capacity: max(L, K) clamped into 1..MAX_LIST
  always_comb begin
    eff_lim = (list_limit_r < result_count_r) ? result_count_r : list_limit_r;
    if (eff_lim > LIST_MAX) eff_lim = LIST_MAX;
    if (eff_lim == '0) eff_lim = CNT_W'(1);
  end

  assign ro_len   = (result_count_r < cand_count_r) ? result_count_r : cand_count_r;
  assign cnt_inc  = cand_count_r + CNT_W'(1);
  assign new_cnt  = (cnt_inc > eff_lim) ? eff_lim : cnt_inc;

  // the shared comparator: stored (key, id) against the offered pair
  assign key_less = {cand_rd_r.key, cand_rd_r.id} < {dk_r, nid_r};

  assign nid_ok     = {16'd0, nid_r} < NODES_W;
  assign start_ok   = {16'd0, start_node_r} < NODES_W;
  assign nid_mask   = MAP_W'(1) << nid_r[MAP_SH-1:0];
  assign start_mask = MAP_W'(1) << start_node_r[MAP_SH-1:0];

  // RAM port control
  always_comb begin
    cand_ra  = i_r;
    cand_wa  = i_r;
    cand_we  = 1'b0;
    cand_wd  = cand_rd_r;
    map_addr = RAW'(nid_r >> MAP_SH);
    map_we   = 1'b0;
    map_wd   = map_rd_r | nid_mask;
    unique case (state_r)
      S_CLR: begin
        map_addr = clr_r;
        map_we   = 1'b1;
        map_wd   = '0;
      end
      S_START_FIN: begin
        map_addr = RAW'(start_node_r >> MAP_SH);
        map_we   = start_ok;
        map_wd   = start_mask;
        cand_wa  = '0;
        cand_we  = 1'b1;
        cand_wd  = '{key: dk_r, id: start_node_r, expd: 1'b0};
      end
      S_VIS_CHK: begin
        map_we = !map_rd_r[nid_r[MAP_SH-1:0]];
      end
      S_SCAN_RD:  cand_ra = p_r;
      S_SCAN_CMP: cand_ra = p_r + CNT_W'(1);  // prefetch next entry
      S_SHIFT_RD: cand_ra = i_r - CNT_W'(1);
      S_SHIFT_WR: cand_we = 1'b1;             // entry i-1 moves up to i
      S_INS: begin
        cand_wa = p_r;
        cand_we = 1'b1;
        cand_wd = '{key: dk_r, id: nid_r, expd: 1'b0};
      end
      S_EXP_CHK: begin
        cand_ra = i_r + CNT_W'(1);
        cand_we = !cand_rd_r.expd;
        cand_wd = '{key: cand_rd_r.key, id: cand_rd_r.id, expd: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cand_we) cand_mem[cand_wa[LW-1:0]] <= cand_wd;
    cand_rd_r <= cand_mem[cand_ra[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_addr] <= map_wd;
    map_rd_r <= map_mem[map_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_limit_r   <= CNT_W'(64);
      result_count_r <= CNT_W'(10);
      start_node_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LIST_LIMIT:   list_limit_r   <= cfg_wr_data[CNT_W-1:0];
        REG_RESULT_COUNT: result_count_r <= cfg_wr_data[CNT_W-1:0];
        REG_START_NODE:   start_node_r   <= cfg_wr_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;    // bitmap sweep after reset
      clr_r        <= '0;
      start_pend_r <= 1'b0;
      cand_count_r <= '0;
      cmp_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLR: begin
          if (clr_r == ROW_LAST) begin
            clr_r   <= '0;
            state_r <= start_pend_r ? S_START_FIN : S_IDLE;
          end else begin
            clr_r <= clr_r + RAW'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            nid_r <= in_ch.node_id;
            dk_r  <= in_ch.dist_key;
            p_r   <= '0;
            i_r   <= '0;
            unique case (in_ch.action)
              ACT_START: begin
                start_pend_r <= 1'b1;
                state_r      <= S_CLR;
              end
              ACT_VISIT: state_r <= S_VIS_RD;
              ACT_OFFER: begin
                if (cmp_r < CMP_MAX) cmp_r <= cmp_r + CMP_W'(1);
                state_r <= (cand_count_r == '0) ? S_DECIDE : S_SCAN_RD;
              end
              ACT_EXPAND: begin
                if (cand_count_r == '0) begin
                  res_st_r   <= ST_EXHAUSTED;
                  res_id_r   <= '0;
                  res_dist_r <= '0;
                  state_r    <= S_EMIT;
                end else begin
                  state_r <= S_EXP_RD;
                end
              end
              ACT_READ: begin
                n_r     <= ro_len;
                state_r <= (ro_len == '0) ? S_IDLE : S_RO_RD;
              end
              default: ;  // unused codes: dropped
            endcase
          end
        end

        S_START_FIN: begin
          start_pend_r <= 1'b0;
          cand_count_r <= CNT_W'(1);
          cmp_r        <= CMP_W'(1);
          res_st_r     <= ST_STARTED;
          res_id_r     <= start_node_r;
          res_dist_r   <= dk_r;
          state_r      <= S_EMIT;
        end

        S_VIS_RD: begin
          if (nid_ok) begin
            state_r <= S_VIS_CHK;
          end else begin
            // out of range ids always read as visited
            res_st_r   <= ST_VISITED;
            res_id_r   <= nid_r;
            res_dist_r <= '0;
            state_r    <= S_EMIT;
          end
        end

        S_VIS_CHK: begin
          res_st_r   <= map_rd_r[nid_r[MAP_SH-1:0]] ? ST_VISITED : ST_NEW;
          res_id_r   <= nid_r;
          res_dist_r <= '0;
          state_r    <= S_EMIT;
        end

        S_SCAN_RD: state_r <= S_SCAN_CMP;

        S_SCAN_CMP: begin
          if (key_less) begin
            p_r <= p_r + CNT_W'(1);
            if (p_r + CNT_W'(1) == cand_count_r) state_r <= S_DECIDE;
          end else begin
            state_r <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (p_r < eff_lim) begin
            cand_count_r <= new_cnt;          // may truncate after a lowered limit
            i_r          <= new_cnt - CNT_W'(1);
            state_r      <= S_SHIFT_RD;
          end else begin
            res_st_r   <= ST_REJECTED;
            res_id_r   <= nid_r;
            res_dist_r <= dk_r;
            state_r    <= S_EMIT;
          end
        end

        S_SHIFT_RD: state_r <= (i_r > p_r) ? S_SHIFT_WR : S_INS;

        S_SHIFT_WR: begin
          i_r     <= i_r - CNT_W'(1);
          state_r <= S_SHIFT_RD;
        end

        S_INS: begin
          res_st_r   <= ST_INSERTED;
          res_id_r   <= nid_r;
          res_dist_r <= dk_r;
          state_r    <= S_EMIT;
        end

        S_EXP_RD: state_r <= S_EXP_CHK;

        S_EXP_CHK: begin
          if (!cand_rd_r.expd) begin
            res_st_r   <= ST_EXPANDED;
            res_id_r   <= cand_rd_r.id;
            res_dist_r <= cand_rd_r.key;
            state_r    <= S_EMIT;
          end else if (i_r + CNT_W'(1) == cand_count_r) begin
            res_st_r   <= ST_EXHAUSTED;
            res_id_r   <= '0;
            res_dist_r <= '0;
            state_r    <= S_EMIT;
          end else begin
            i_r <= i_r + CNT_W'(1);
          end
        end

        S_RO_RD: state_r <= S_RO_OUT;

        S_RO_OUT: begin
          // read address stays on i, so the entry holds while the output stalls
          if (out_free) begin
            out_st_r    <= ST_RESULT;
            out_id_r    <= cand_rd_r.id;
            out_dist_r  <= cand_rd_r.key;
            out_cmp_r   <= cmp_r;
            out_last_r  <= (i_r + CNT_W'(1) == n_r);
            i_r         <= i_r + CNT_W'(1);
            state_r     <= (i_r + CNT_W'(1) == n_r) ? S_IDLE : S_RO_RD;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_st_r    <= res_st_r;
            out_id_r    <= res_id_r;
            out_dist_r  <= res_dist_r;
            out_cmp_r   <= cmp_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/gcl_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [gcl_pkg::ACTION_W-1:0]    in_action,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [gcl_pkg::STATUS_W-1:0]    out_status,
  input logic [gcl_pkg::CMP_W-1:0]       out_compare_count,
  input logic                            out_last
);
  import gcl_pkg::*;

  `GCL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `GCL_ASSERT(a_busy_after_beat, in_valid && in_ready && (in_action < ACT_READ) |=> !in_ready)
  `GCL_ASSERT(a_multi_is_result, out_valid && !out_last |-> out_status == ST_RESULT)
  `GCL_ASSERT(a_cmp_saturates, out_valid |-> out_compare_count <= CMP_MAX)
  `GCL_ASSERT(a_start_seeds, out_valid && out_status == ST_STARTED |-> out_compare_count == 17'd1 && out_last)

endmodule

bind graph_search_candidate_list gcl_checker u_gcl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_action         (in_ch.action),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_compare_count (out_ch.compare_count),
  .out_last          (out_ch.last)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gcl_pkg::*;

  localparam int LIST_DEPTH = 64;     // MAX_LIST of the instance
  localparam int SETTLE_CYC = 64;     // quiet time after the last result before a cfg write
  localparam int END_CYC    = 200;    // quiet time before the verdict
  localparam int MAX_PRINTS = 40;

  // action codes the block must ignore
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     node;
    logic [DIST_W-1:0]   key;
    logic [CMP_W-1:0]    cmp;
    logic                last;
  } result_beat_t;

  // Shadow of the visited bitmap and the sorted candidate list; predicts every
  // result beat and checks the DUT's beats against them in order.
  class cand_list_tracker;
    bit                visited [ID_SPACE];
    logic [DIST_W-1:0] c_dist  [LIST_DEPTH];
    logic [ID_W-1:0]   c_id    [LIST_DEPTH];
    bit                c_expd  [LIST_DEPTH];
    int                c_count;
    int                cmp_total;
    int                list_limit;
    int                result_count;
    logic [ID_W-1:0]   start_node;
    result_beat_t      due_beats [$];
    int                mismatches;
    int                beats_checked;

    function new();
      list_limit    = 64;
      result_count  = 10;
      start_node    = '0;
      c_count       = 0;
      cmp_total     = 0;
      mismatches    = 0;
      beats_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LIST_LIMIT:   list_limit   = int'(val[CNT_W-1:0]);
        REG_RESULT_COUNT: result_count = int'(val[CNT_W-1:0]);
        REG_START_NODE:   start_node   = val;
        default: ;
      endcase
    endfunction

    // capacity is raised to K and clamped to the list depth
    function int capacity();
      int cap;
      cap = (list_limit < result_count) ? result_count : list_limit;
      if (cap > LIST_DEPTH) cap = LIST_DEPTH;
      if (cap < 1) cap = 1;
      return cap;
    endfunction

    function void due(logic [STATUS_W-1:0] st, logic [ID_W-1:0] node,
                      logic [DIST_W-1:0] dkey, bit last);
      result_beat_t b;
      b.status = st;
      b.node   = node;
      b.key    = dkey;
      b.cmp    = CMP_W'(cmp_total);
      b.last   = last;
      due_beats = {due_beats, b};
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic [ID_W-1:0] node,
                               logic [DIST_W-1:0] dkey);
      int lim;
      int pos;
      int nc;
      int n;
      bit found;
      case (act)
        ACT_START: begin
          foreach (visited[i]) visited[i] = 1'b0;
          c_dist[0]           = dkey;
          c_id[0]             = start_node;
          c_expd[0]           = 1'b0;
          c_count             = 1;
          visited[start_node] = 1'b1;
          cmp_total           = 1;
          due(ST_STARTED, start_node, dkey, 1'b1);
        end
        ACT_VISIT: begin
          if (!visited[node]) begin
            visited[node] = 1'b1;
            due(ST_NEW, node, '0, 1'b1);
          end else begin
            due(ST_VISITED, node, '0, 1'b1);
          end
        end
        ACT_OFFER: begin
          lim = capacity();
          if (cmp_total < int'(CMP_MAX)) cmp_total++;
          // position = number of entries strictly below (key, id)
          pos = 0;
          while (pos < c_count &&
                 (c_dist[pos] < dkey || (c_dist[pos] == dkey && c_id[pos] < node)))
            pos++;
          if (pos < lim) begin
            // a lowered limit truncates here; a full list loses its tail
            nc = (c_count + 1 > lim) ? lim : c_count + 1;
            for (int i = nc - 1; i > pos; i--) begin
              c_dist[i] = c_dist[i-1];
              c_id[i]   = c_id[i-1];
              c_expd[i] = c_expd[i-1];
            end
            c_dist[pos] = dkey;
            c_id[pos]   = node;
            c_expd[pos] = 1'b0;
            c_count     = nc;
            due(ST_INSERTED, node, dkey, 1'b1);
          end else begin
            due(ST_REJECTED, node, dkey, 1'b1);
          end
        end
        ACT_EXPAND: begin
          found = 1'b0;
          for (int i = 0; i < c_count && !found; i++) begin
            if (!c_expd[i]) begin
              c_expd[i] = 1'b1;
              found     = 1'b1;
              due(ST_EXPANDED, c_id[i], c_dist[i], 1'b1);
            end
          end
          if (!found) due(ST_EXHAUSTED, '0, '0, 1'b1);
        end
        ACT_READ: begin
          n = (result_count < c_count) ? result_count : c_count;
          for (int i = 0; i < n; i++) due(ST_RESULT, c_id[i], c_dist[i], i == n - 1);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_beat(result_beat_t got);
      result_beat_t want;
      if (due_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: status %0d node %0d dist %0d",
                                  got.status, got.node, got.key));
        return;
      end
      want = due_beats.pop_front();
      beats_checked++;
      if (got.status !== want.status)
        report_mismatch($sformatf("beat %0d status: got %0d want %0d",
                                  beats_checked, got.status, want.status));
      if (got.node !== want.node)
        report_mismatch($sformatf("beat %0d node_id_out: got %0d want %0d",
                                  beats_checked, got.node, want.node));
      if (got.key !== want.key)
        report_mismatch($sformatf("beat %0d dist_out: got %0h want %0h",
                                  beats_checked, got.key, want.key));
      if (got.cmp !== want.cmp)
        report_mismatch($sformatf("beat %0d compare_count: got %0d want %0d",
                                  beats_checked, got.cmp, want.cmp));
      if (got.last !== want.last)
        report_mismatch($sformatf("beat %0d last: got %0b want %0b",
                                  beats_checked, got.last, want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  gcl_in_if  in_ch ();
  gcl_out_if out_ch ();

  graph_search_candidate_list u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  cand_list_tracker sb = new();

  // Idling controls: tx_gaps lets the sender skip cycles, rx_stalls lets the
  // result side hold ready low. allow_idle gates both per search.
  bit tx_gaps;
  bit rx_stalls;
  bit allow_idle;
  int rx_hold = 0;

  int beats_sent;
  int searches;
  int settings_used;

  always #2 clk = ~clk;

  // Result side: ready drops low in random bursts when stalls are enabled.
  always @(negedge clk) begin
    if (rx_stalls && rx_hold == 0 && $urandom_range(0, 5) == 0)
      rx_hold = $urandom_range(1, 19);
    if (rx_stalls && rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted result beat goes to the checker, fields packed in struct order.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.status, out_ch.node_id_out, out_ch.dist_out,
                     out_ch.compare_count, out_ch.last});
  end

  // One request beat: optional gap, drive on the falling edge, hold until taken.
  // valid stays high into the next call so back-to-back beats never glitch it.
  task automatic issue(logic [ACTION_W-1:0] act, logic [ID_W-1:0] node,
                       logic [DIST_W-1:0] dkey);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.node_id  <= node;
    in_ch.dist_key <= dkey;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(act, node, dkey);
    if (act < ACT_SPARE_LO) beats_sent++;
  endtask

  // Stop sending and wait for every predicted beat, then a quiet stretch.
  task automatic drain(int settle);
    @(negedge clk) in_ch.valid <= 1'b0;
    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= CFG_DATA_W'(val);
    @(posedge clk);
    sb.write_reg(idx, CFG_DATA_W'(val));
  endtask

  // Registers are only touched once the block has gone quiet.
  task automatic apply_settings(int lim, int cnt, int seed_node);
    drain(SETTLE_CYC);
    put_reg(REG_LIST_LIMIT, lim);
    put_reg(REG_RESULT_COUNT, cnt);
    put_reg(REG_START_NODE, seed_node);
    @(negedge clk) cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Node ids lean on a small pool and the seed so visit checks hit marked nodes.
  function automatic logic [ID_W-1:0] pick_node();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return sb.start_node;
      4, 5, 6: return ID_W'($urandom_range(0, 63));
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Small keys give distance ties, so the id tie-break gets exercised.
  function automatic logic [DIST_W-1:0] pick_dist();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return DIST_W'($urandom_range(0, 31));
      default:    return DIST_W'($urandom);
    endcase
  endfunction

  // A search as the host would run it: expand the best, check its neighbors,
  // offer the new ones, read out now and then. About one step in twenty is
  // noise: any action code with random fields.
  task automatic run_search(int n_items, bit fresh);
    int               done;
    int               fanout;
    logic [ID_W-1:0]  node;
    logic [ACTION_W-1:0] act;
    bit               unseen;
    tx_gaps   = allow_idle && $urandom_range(0, 9) < 7;
    rx_stalls = allow_idle && $urandom_range(0, 9) < 7;
    done = 0;
    if (fresh) begin
      issue(ACT_START, pick_node(), pick_dist());
      searches++;
      done++;
    end
    while (done < n_items) begin
      // now and then let the result side run completely dry
      if ($urandom_range(0, 29) == 0) drain(0);
      case ($urandom_range(0, 19))
        0: begin
          act = ACTION_W'($urandom_range(0, 7));
          // keep restarts rare: each one sweeps the whole bitmap
          if (act == ACT_START && $urandom_range(0, 3) != 0) act = ACT_OFFER;
          if (act == ACT_START) searches++;
          issue(act, ID_W'($urandom), DIST_W'($urandom));
          if (act < ACT_SPARE_LO) done++;
        end
        1: begin
          issue(ACT_READ, ID_W'($urandom), DIST_W'($urandom));
          done++;
        end
        default: begin
          issue(ACT_EXPAND, ID_W'($urandom), DIST_W'($urandom));
          done++;
          fanout = $urandom_range(1, 4);
          repeat (fanout) begin
            node   = pick_node();
            unseen = !sb.visited[node];
            issue(ACT_VISIT, node, DIST_W'($urandom));
            done++;
            // mostly offer only fresh neighbors, sometimes a revisit anyway
            if (unseen || $urandom_range(0, 9) == 0) begin
              issue(ACT_OFFER, node, pick_dist());
              done++;
            end
          end
        end
      endcase
    end
    issue(ACT_READ, ID_W'($urandom), DIST_W'($urandom));
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wr_data    = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = '0;
    in_ch.node_id  = '0;
    in_ch.dist_key = '0;
    out_ch.ready   = 1'b0;
    tx_gaps        = 1'b0;
    rx_stalls      = 1'b0;
    allow_idle     = 1'b0;
    beats_sent     = 0;
    searches       = 0;
    settings_used  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // ---- directed, reset register values (L=64, K=10, seed node 0) ----
    // empty list: read-out yields nothing, expand reports exhausted
    issue(ACT_READ, '0, '0);
    issue(ACT_EXPAND, '0, '0);
    // top node id: first check marks it, second sees it marked
    issue(ACT_VISIT, '1, '0);
    issue(ACT_VISIT, '1, '0);
    // offer into a never-seeded list, counter climbs from zero
    issue(ACT_OFFER, 16'h1234, 32'd100);
    // spare action codes, all other bits high: must be ignored
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) issue(ACTION_W'(a), '1, '1);
    // seed with the largest key; start clears the bitmap
    issue(ACT_START, '1, '1);
    searches++;
    issue(ACT_VISIT, '0, '0);
    issue(ACT_VISIT, '1, '0);
    // ordering: equal keys sort by id, duplicates go ahead of their twin
    issue(ACT_OFFER, '1, '1);
    issue(ACT_OFFER, 16'd3, 32'd7);
    issue(ACT_OFFER, 16'd2, 32'd7);
    issue(ACT_OFFER, '0, '0);
    issue(ACT_OFFER, 16'd2, 32'd7);
    issue(ACT_EXPAND, '0, '0);
    issue(ACT_EXPAND, '0, '0);
    issue(ACT_READ, '0, '0);
    // walk the rest of the list until it runs out
    repeat (5) issue(ACT_EXPAND, '0, '0);

    // ---- random searches over a range of list settings ----
    allow_idle = 1'b1;
    apply_settings(16, 8, $urandom_range(0, 65535));
    run_search(25, 1'b1);
    // shrink the limit mid-search: the next insert truncates the list
    apply_settings(5, 3, $urandom_range(0, 65535));
    run_search(25, 1'b0);
    // deepest list and full read-out; flood it so the tail gets dropped
    apply_settings(64, 64, 65535);
    run_search(20, 1'b1);
    repeat (70) issue(ACT_OFFER, pick_node(), pick_dist());
    issue(ACT_READ, '0, '0);
    apply_settings(1, 1, $urandom_range(0, 65535));
    run_search(20, 1'b1);
    // K above L: capacity is raised to K
    apply_settings(3, 40, 0);
    run_search(30, 1'b1);
    apply_settings(64, 1, $urandom_range(0, 65535));
    run_search(25, 1'b1);
    repeat (2) begin
      apply_settings($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 65535));
      run_search(20, 1'b1);
    end

    // ---- closing stretch, no idling on either side ----
    allow_idle = 1'b0;
    apply_settings($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 65535));
    run_search(20, 1'b1);
    // one-entry list seeded at key 0: every later offer is rejected
    apply_settings(1, 1, $urandom_range(0, 65535));
    issue(ACT_START, pick_node(), '0);
    searches++;
    repeat (10) issue(ACT_OFFER, ID_W'($urandom), DIST_W'($urandom) | DIST_W'(1));
    issue(ACT_READ, '0, '0);
    issue(ACT_EXPAND, '0, '0);
    issue(ACT_EXPAND, '0, '0);

    drain(END_CYC);
    $display("Covered %0d request beats in %0d searches under %0d register settings,",
             beats_sent, searches, settings_used);
    $display("with gaps and stalls on both sides; %0d result beats checked in order.",
             sb.beats_checked);
    if (sb.mismatches == 0 && sb.due_beats.size() == 0) begin
      $display("** graph_search_candidate_list: PASSED **");
    end else begin
      $display("** graph_search_candidate_list: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Watchdog expired with %0d result beats still outstanding",
             sb.due_beats.size());
    $display("** graph_search_candidate_list: FAILED **");
    $finish;
  end

endmodule
